/* rtl/atce_pkg.sv */
// Package of the truecolor escape encoder: types, byte constants and the decimal split.
package atce_pkg;

  localparam int SlotW = 5;
  typedef logic [SlotW-1:0] slot_t;

  // Slot plan of one cell: seven head bytes, then three groups of four slots
  // (hundreds, tens, ones, separator or final letter), then the glyph.
  localparam slot_t SLOT_HEAD0 = 5'd0;
  localparam slot_t SLOT_DIG0  = 5'd7;
  localparam slot_t SLOT_GLYPH = 5'd19;

  localparam logic [1:0] SUB_HUND = 2'd0;
  localparam logic [1:0] SUB_TENS = 2'd1;
  localparam logic [1:0] SUB_ONES = 2'd2;
  localparam logic [1:0] SUB_SEP  = 2'd3;

  localparam logic [1:0] GRP_RED   = 2'd0;
  localparam logic [1:0] GRP_GREEN = 2'd1;
  localparam logic [1:0] GRP_BLUE  = 2'd2;

  localparam logic [7:0] HEAD_BYTES [7] = '{8'd27, 8'd91, 8'd51, 8'd56, 8'd59, 8'd50, 8'd59};
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] SEP_BYTE   = 8'd59;
  localparam logic [7:0] FINAL_BYTE = 8'd109;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  // Splits a byte into decimal digits. v/10 is taken as (v*205)>>11, exact for v below 1029.
  function automatic dec_t split_dec(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [1:0]  h;
    dec_t        d;
    prod = 16'(v) * 16'd205;
    q    = prod[15:11];
    h    = (q >= 5'd20) ? 2'd2 : ((q >= 5'd10) ? 2'd1 : 2'd0);
    d.hund = h;
    d.tens = 4'(q - 5'(h) * 5'd10);
    d.ones = 4'(v - 8'(q) * 8'd10);
    return d;
  endfunction

endpackage

/* rtl/atce_if.sv */
// Stream interfaces of the truecolor escape encoder: cell requests in, bytes out.
interface atce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] glyph;
  logic       new_frame;
  modport source (output valid, red, green, blue, glyph, new_frame, input ready);
  modport sink   (input valid, red, green, blue, glyph, new_frame, output ready);
endinterface

interface atce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

/* rtl/ansi_truecolor_escape_encoder.sv */
// Top level of the truecolor escape encoder: cell register, slot sequencer, byte register.
// Timing: a byte enters the output register when its slot is reached and the sequencer
// advances; the first byte of a cell passes the cell register and then the output register.
// Per cell, the slot counter walks twenty slots for a cell with a color change (unused digit
// slots included, stalled while the output register is full) and one slot for a glyph-only cell.
// Reset (synchronous, rst_n low): no cell held, output empty, no color remembered.
module ansi_truecolor_escape_encoder import atce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  atce_in_if.sink     in_req,
  atce_out_if.source  out_req
);

  // Remembered color. It is updated when a cell is accepted, since the decision to
  // emit an escape is made right there.
  logic [7:0] prev_red_r, prev_green_r, prev_blue_r;
  logic       color_known_r;

  // Cell register: the glyph and the decimal digits of the cell being sent.
  logic       hold_valid_r;
  logic [7:0] glyph_r;
  dec_t       dec_red_r, dec_green_r, dec_blue_r;
  slot_t      slot_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       in_fire;
  logic       need_esc;
  logic       advance;
  logic       cell_done;
  logic [7:0] cur_byte;
  logic       cur_emit;
  logic       cur_last;
  logic [3:0] dig_off;
  dec_t       cur_dec;

  // The sequencer moves whenever a cell is held and the output register is free or being drained.
  assign advance   = hold_valid_r && (!out_valid_r || out_req.ready);
  assign cell_done = advance && (slot_r == SLOT_GLYPH);

  // A new cell enters while the previous one sends its glyph, so cells flow back to back.
  assign in_req.ready = !hold_valid_r || cell_done;
  assign in_fire      = in_req.valid && in_req.ready;

  // A frame start forgets the remembered color before the comparison.
  assign need_esc = in_req.new_frame || !color_known_r ||
                    (in_req.red != prev_red_r) || (in_req.green != prev_green_r) ||
                    (in_req.blue != prev_blue_r);

  // Byte for the current slot. Digit slots that would print a leading zero are skipped
  // by sending nothing in that cycle.
  assign dig_off = 4'(slot_r - SLOT_DIG0);

  always_comb begin
    case (dig_off[3:2])
      GRP_RED:   cur_dec = dec_red_r;
      GRP_GREEN: cur_dec = dec_green_r;
      default:   cur_dec = dec_blue_r;
    endcase
    cur_byte = glyph_r;
    cur_emit = 1'b1;
    cur_last = 1'b0;
    if (slot_r < SLOT_DIG0) begin
      cur_byte = HEAD_BYTES[slot_r[2:0]];
    end else if (slot_r == SLOT_GLYPH) begin
      cur_byte = glyph_r;
      cur_last = 1'b1;
    end else begin
      case (dig_off[1:0])
        SUB_HUND: begin
          cur_byte = DIGIT_ZERO + 8'(cur_dec.hund);
          cur_emit = (cur_dec.hund != 2'd0);
        end
        SUB_TENS: begin
          cur_byte = DIGIT_ZERO + 8'(cur_dec.tens);
          cur_emit = (cur_dec.hund != 2'd0) || (cur_dec.tens != 4'd0);
        end
        SUB_ONES: begin
          cur_byte = DIGIT_ZERO + 8'(cur_dec.ones);
        end
        default: begin
          cur_byte = (dig_off[3:2] == GRP_BLUE) ? FINAL_BYTE : SEP_BYTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r  <= 1'b0;
      slot_r        <= SLOT_HEAD0;
      color_known_r <= 1'b0;
      prev_red_r    <= 8'd0;
      prev_green_r  <= 8'd0;
      prev_blue_r   <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        hold_valid_r  <= 1'b1;
        slot_r        <= need_esc ? SLOT_HEAD0 : SLOT_GLYPH;
        color_known_r <= 1'b1;
        prev_red_r    <= in_req.red;
        prev_green_r  <= in_req.green;
        prev_blue_r   <= in_req.blue;
      end else if (cell_done) begin
        hold_valid_r <= 1'b0;
      end else if (advance) begin
        slot_r <= slot_r + 5'd1;
      end
      if (advance) begin
        out_valid_r <= cur_emit;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      glyph_r     <= in_req.glyph;
      dec_red_r   <= split_dec(in_req.red);
      dec_green_r <= split_dec(in_req.green);
      dec_blue_r  <= split_dec(in_req.blue);
    end
    if (advance && cur_emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
    end
  end

  assign out_req.valid       = out_valid_r;
  assign out_req.out_byte    = out_byte_r;
  assign out_req.last_of_run = out_last_r;

  // The slot counter never runs past the glyph slot.
  assert property (@(posedge clk) disable iff (!rst_n) slot_r <= SLOT_GLYPH)
    else $error("slot counter past glyph slot");

  // A cell is taken only when nothing is held or the held cell finishes now.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!hold_valid_r || (advance && slot_r == SLOT_GLYPH)))
    else $error("cell accepted over a busy cell register");

  // An accepted cell with a color change starts at the first head byte, and the color
  // is remembered afterwards.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && need_esc) |=> (slot_r == SLOT_HEAD0 && color_known_r && hold_valid_r))
    else $error("escape cell did not start at the head");

  // The glyph byte is the only byte that closes a cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_emit && slot_r != SLOT_GLYPH) |=> !out_last_r)
    else $error("escape byte marked as last");

endmodule

/* tb/tb_ansi_truecolor_escape_encoder.sv */
// Testbench of the truecolor escape encoder: directed and random cells, byte stream checked.
`timescale 1ns / 1ps

module tb_ansi_truecolor_escape_encoder;
  import atce_pkg::*;

  // One byte of the terminal stream as the encoder should produce it.
  typedef struct {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  logic clk;
  logic rst_n;

  atce_in_if  in_req ();
  atce_out_if out_req ();

  ansi_truecolor_escape_encoder u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_req (out_req)
  );

  // Clock with a period of 8 ns.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes still owed by the encoder, oldest first.
  stream_byte_t pending_bytes[$];

  // Our own copy of the remembered color, updated when a cell request is accepted.
  logic [7:0] seen_red;
  logic [7:0] seen_green;
  logic [7:0] seen_blue;
  logic       seen_valid;

  // Last color that was sent, used to build runs of equal colors in the random part.
  logic [7:0] sent_red;
  logic [7:0] sent_green;
  logic [7:0] sent_blue;

  // Idling switches for both sides; clearing them gives stretches at full rate.
  bit in_idle_on;
  bit out_idle_on;

  int mismatches;
  int cells_sent;
  int escapes_expected;
  int bytes_checked;

  // Gap length in cycles: none when disabled, else mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int gap_cycles(input bit enabled);
    int pick;
    pick = $urandom_range(0, 99);
    if (!enabled || pick < 60) begin
      return 0;
    end
    if (pick < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_stream_byte(input logic [7:0] value, input logic last);
    stream_byte_t sb;
    sb.value = value;
    sb.last  = last;
    pending_bytes.push_back(sb);
  endfunction

  // Decimal digits of one color component, with no leading zeros.
  function automatic void push_decimal(input logic [7:0] v);
    int hundreds;
    int tens;
    int ones;
    hundreds = v / 100;
    tens     = (v / 10) % 10;
    ones     = v % 10;
    if (hundreds != 0) begin
      push_stream_byte(DIGIT_ZERO + 8'(hundreds), 1'b0);
    end
    if (hundreds != 0 || tens != 0) begin
      push_stream_byte(DIGIT_ZERO + 8'(tens), 1'b0);
    end
    push_stream_byte(DIGIT_ZERO + 8'(ones), 1'b0);
  endfunction

  // Works out the bytes of one accepted cell: the color escape when the color is new or
  // forgotten, then the glyph, which closes the cell.
  function automatic void predict_cell_bytes(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] ch,
                                             input logic nf);
    if (nf) begin
      seen_valid = 1'b0;
    end
    if (!seen_valid || r != seen_red || g != seen_green || b != seen_blue) begin
      for (int i = 0; i < 7; i++) begin
        push_stream_byte(HEAD_BYTES[i], 1'b0);
      end
      push_decimal(r);
      push_stream_byte(SEP_BYTE, 1'b0);
      push_decimal(g);
      push_stream_byte(SEP_BYTE, 1'b0);
      push_decimal(b);
      push_stream_byte(FINAL_BYTE, 1'b0);
      seen_red   = r;
      seen_green = g;
      seen_blue  = b;
      seen_valid = 1'b1;
      escapes_expected++;
    end
    push_stream_byte(ch, 1'b1);
  endfunction

  // Sends one cell request. It is entered right after a rising edge and returns at the
  // edge where the request was accepted, so back-to-back requests keep valid high.
  task automatic send_cell(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] ch, input logic nf);
    int gap;
    gap = gap_cycles(in_idle_on);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.red       <= r;
    in_req.green     <= g;
    in_req.blue      <= b;
    in_req.glyph     <= ch;
    in_req.new_frame <= nf;
    do begin
      @(posedge clk);
    end while (!in_req.ready);
    predict_cell_bytes(r, g, b, ch, nf);
    sent_red   = r;
    sent_green = g;
    sent_blue  = b;
    cells_sent++;
  endtask

  // Output side: ready is held high for a while, then dropped for a random gap.
  initial begin
    int gap;
    out_req.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = gap_cycles(out_idle_on);
      if (gap > 0) begin
        out_req.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_req.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Each accepted byte is checked against the oldest owed byte.
  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n && out_req.valid && out_req.ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: byte with none expected: out_byte %0d last_of_run %0b",
                 $time, out_req.out_byte, out_req.last_of_run);
      end else begin
        want = pending_bytes.pop_front();
        if (out_req.out_byte !== want.value) begin
          mismatches++;
          $display("%0t: out_byte expected %0d actual %0d",
                   $time, want.value, out_req.out_byte);
        end
        if (out_req.last_of_run !== want.last) begin
          mismatches++;
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, want.last, out_req.last_of_run);
        end
      end
    end
  end

  // The very first cell must carry an escape, even for black; a repeat is glyph only.
  task automatic test_first_cell();
    send_cell(8'd0, 8'd0, 8'd0, 8'h41, 1'b0);
    send_cell(8'd0, 8'd0, 8'd0, 8'h42, 1'b0);
  endtask

  // White is an ordinary color: repeating it gives the glyph alone, a frame start
  // forces the escape again.
  task automatic test_white();
    send_cell(8'd255, 8'd255, 8'd255, 8'h57, 1'b0);
    send_cell(8'd255, 8'd255, 8'd255, 8'h77, 1'b0);
    send_cell(8'd255, 8'd255, 8'd255, 8'h2a, 1'b1);
  endtask

  // Components of one, two and three digits, zero tens in a three-digit value, and the
  // longest escape (all three components of three digits).
  task automatic test_digit_widths();
    send_cell(8'd9, 8'd10, 8'd99, 8'h61, 1'b0);
    send_cell(8'd100, 8'd205, 8'd250, 8'h62, 1'b0);
    send_cell(8'd100, 8'd100, 8'd100, 8'h63, 1'b0);
    send_cell(8'd0, 8'd128, 8'd7, 8'h64, 1'b0);
    send_cell(8'd199, 8'd0, 8'd55, 8'h65, 1'b0);
    send_cell(8'd199, 8'd0, 8'd56, 8'h66, 1'b0);
    send_cell(8'd200, 8'd0, 8'd56, 8'h67, 1'b0);
  endtask

  // Frame start on an unchanged color still emits the escape; without it, not.
  task automatic test_frame_start();
    send_cell(8'd200, 8'd0, 8'd56, 8'h68, 1'b1);
    send_cell(8'd200, 8'd0, 8'd56, 8'h69, 1'b0);
    send_cell(8'd12, 8'd34, 8'd56, 8'h6a, 1'b1);
  endtask

  // Glyph extremes and glyphs that look like escape bytes.
  task automatic test_glyph_values();
    send_cell(8'd12, 8'd34, 8'd56, 8'h00, 1'b0);
    send_cell(8'd12, 8'd34, 8'd56, 8'hff, 1'b0);
    send_cell(8'd1, 8'd2, 8'd3, 8'd27, 1'b0);
    send_cell(8'd1, 8'd2, 8'd3, 8'd109, 1'b0);
  endtask

  // Random cells. Most keep or revisit a color so that glyph-only cells and single
  // component changes are frequent; the rest are fresh colors with mixed digit counts.
  task automatic test_random_cells(input int count);
    logic [7:0] palette_red   [4];
    logic [7:0] palette_green [4];
    logic [7:0] palette_blue  [4];
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         pick;
    int         slot;
    for (int i = 0; i < 4; i++) begin
      palette_red[i]   = 8'($urandom_range(0, 255));
      palette_green[i] = 8'($urandom_range(0, 255));
      palette_blue[i]  = 8'($urandom_range(0, 255));
    end
    for (int n = 0; n < count; n++) begin
      // Now and then the idling on either side is switched, to get full-rate stretches.
      if ($urandom_range(0, 24) == 0) begin
        in_idle_on = !in_idle_on;
      end
      if ($urandom_range(0, 24) == 0) begin
        out_idle_on = !out_idle_on;
      end
      r    = sent_red;
      g    = sent_green;
      b    = sent_blue;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Same color as the last cell.
      end else if (pick < 60) begin
        slot = $urandom_range(0, 3);
        r    = palette_red[slot];
        g    = palette_green[slot];
        b    = palette_blue[slot];
      end else if (pick < 72) begin
        slot = $urandom_range(0, 2);
        case (slot)
          0: r = 8'($urandom_range(0, 255));
          1: g = 8'($urandom_range(0, 255));
          default: b = 8'($urandom_range(0, 255));
        endcase
      end else begin
        r = 8'($urandom_range(0, 255) >> $urandom_range(0, 7));
        g = 8'($urandom_range(0, 255) >> $urandom_range(0, 7));
        b = 8'($urandom_range(0, 255) >> $urandom_range(0, 7));
      end
      send_cell(r, g, b, 8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.red       <= 8'd0;
    in_req.green     <= 8'd0;
    in_req.blue      <= 8'd0;
    in_req.glyph     <= 8'd0;
    in_req.new_frame <= 1'b0;
    seen_red         = 8'd0;
    seen_green       = 8'd0;
    seen_blue        = 8'd0;
    seen_valid       = 1'b0;
    sent_red         = 8'd0;
    sent_green       = 8'd0;
    sent_blue        = 8'd0;
    mismatches       = 0;
    cells_sent       = 0;
    escapes_expected = 0;
    bytes_checked    = 0;
    // The first directed cells go through at full rate on the input side.
    in_idle_on       = 1'b0;
    out_idle_on      = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_cell();
    in_idle_on = 1'b1;
    test_white();
    test_digit_widths();
    out_idle_on = 1'b0;
    test_frame_start();
    out_idle_on = 1'b1;
    test_glyph_values();
    test_random_cells(160);
    in_req.valid <= 1'b0;

    // Drain, then leave room for a stray byte after the last glyph.
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    $display("Sent %0d cells, %0d of them with a color escape; checked %0d stream bytes.",
             cells_sent, escapes_expected, bytes_checked);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case the encoder hangs.
  initial begin
    #6_000_000;
    $display("Timed out with %0d bytes still owed.", pending_bytes.size());
    $display("status: fail");
    $finish;
  end

endmodule
